### design/apq_pkg.sv
// apq_pkg: shared constants, request and status codes, and transfer structs
// for the array priority queue. No dependencies.
package apq_pkg;

	localparam int DEPTH     = 16;
	localparam int PRIO_BITS = 8;
	localparam int DATA_W    = 32;
	localparam int IDX_W     = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);

	localparam logic [1:0] REQ_ENQ  = 2'd0;
	localparam logic [1:0] REQ_DEQ  = 2'd1;
	localparam logic [1:0] REQ_PEEK = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;

	typedef struct packed {
		logic [1:0]               req_type;
		logic signed [DATA_W-1:0] data_in;
		logic [7:0]               priority_in;
	} req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] data_out;
		logic [4:0]               occupancy;
	} rsp_t;

	typedef struct packed {
		logic [DATA_W-1:0]    data;
		logic [PRIO_BITS-1:0] prio;
	} entry_t;

endpackage

### design/apq_ram.sv
// apq_ram: generic single write port, single read port RAM with registered
// read data. No dependencies.
module apq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### design/array_priority_queue.sv
// array_priority_queue: top level, sequencer around one entry RAM and one
// priority comparator. Depends on apq_pkg and apq_ram.
//
// Requests are taken while busy is low. Enqueue, enqueue on a full queue,
// dequeue or peek on an empty queue and the unused request code give their
// result in the cycle after start. A peek reads every held entry through the
// single RAM read port, one per cycle, before its result is registered. A
// dequeue then moves each entry behind the winner down one place, one per
// cycle. The result is shown on rsp for exactly one cycle while done is high,
// and the receiver cannot stall it.
module array_priority_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  apq_pkg::req_t req,
	output logic          done,
	output apq_pkg::rsp_t rsp
);
	import apq_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT
	} state_t;

	state_t                 state_q;
	logic [CNT_W-1:0]       count_q;
	logic [IDX_W-1:0]       idx_q;
	logic [IDX_W-1:0]       best_idx_q;
	logic [PRIO_BITS-1:0]   best_prio_q;
	logic [DATA_W-1:0]      best_data_q;
	logic                   deq_q;
	logic                   done_q;
	rsp_t                   rsp_q;

	entry_t                 rd_entry;
	entry_t                 wr_entry;
	logic                   wr_en;
	logic [IDX_W-1:0]       wr_addr;
	logic [IDX_W-1:0]       rd_addr;
	logic                   is_better;
	logic [IDX_W-1:0]       new_best_idx;
	logic [PRIO_BITS-1:0]   new_best_prio;
	logic [DATA_W-1:0]      new_best_data;
	logic                   last_scan;
	logic                   last_shift;
	logic                   need_shift;
	logic                   full;
	logic [CNT_W-1:0]       count_m1;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign count_m1 = count_q - CNT_W'(1);

	// shared comparator: strict compare keeps the earliest of equal priorities
	assign is_better     = (idx_q == '0) || (rd_entry.prio > best_prio_q);
	assign new_best_idx  = is_better ? idx_q : best_idx_q;
	assign new_best_prio = is_better ? rd_entry.prio : best_prio_q;
	assign new_best_data = is_better ? rd_entry.data : best_data_q;

	assign last_scan  = (CNT_W'(idx_q) == count_m1);
	assign need_shift = deq_q && (CNT_W'(new_best_idx) != count_m1);
	assign last_shift = ((CNT_W'(idx_q) + CNT_W'(2)) == count_q);

	always_comb begin
		rd_addr = '0;
		unique case (state_q)
			S_IDLE:  rd_addr = '0;
			S_SCAN:  rd_addr = last_scan ? new_best_idx + IDX_W'(1) : idx_q + IDX_W'(1);
			S_SHIFT: rd_addr = idx_q + IDX_W'(2);
			default: rd_addr = '0;
		endcase
	end

	always_comb begin
		wr_en         = 1'b0;
		wr_addr       = idx_q;
		wr_entry      = rd_entry;
		if (state_q == S_IDLE) begin
			wr_en         = start && (req.req_type == REQ_ENQ) && !full;
			wr_addr       = count_q[IDX_W-1:0];
			wr_entry.data = req.data_in;
			wr_entry.prio = req.priority_in[PRIO_BITS-1:0];
		end else if (state_q == S_SHIFT) begin
			wr_en = 1'b1;
		end
	end

	apq_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_entry),
		.raddr (rd_addr),
		.rdata (rd_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			best_idx_q  <= '0;
			best_prio_q <= '0;
			best_data_q <= '0;
			deq_q       <= 1'b0;
			done_q      <= 1'b0;
			rsp_q       <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						unique case (req.req_type) inside
							REQ_ENQ: begin
								done_q         <= 1'b1;
								rsp_q.data_out <= '0;
								if (full) begin
									rsp_q.status    <= ST_OVERFLOW;
									rsp_q.occupancy <= 5'(count_q);
								end else begin
									rsp_q.status    <= ST_OK;
									rsp_q.occupancy <= 5'(count_q + CNT_W'(1));
									count_q         <= count_q + CNT_W'(1);
								end
							end
							REQ_DEQ, REQ_PEEK: begin
								if (count_q == '0) begin
									done_q          <= 1'b1;
									rsp_q.status    <= ST_UNDERFLOW;
									rsp_q.data_out  <= '0;
									rsp_q.occupancy <= '0;
								end else begin
									done_q  <= 1'b0;
									state_q <= S_SCAN;
									idx_q   <= '0;
									deq_q   <= (req.req_type == REQ_DEQ);
								end
							end
							default: begin
								done_q          <= 1'b1;
								rsp_q.status    <= ST_OK;
								rsp_q.data_out  <= '0;
								rsp_q.occupancy <= 5'(count_q);
							end
						endcase
					end else begin
						done_q <= 1'b0;
					end
				end
				S_SCAN: begin
					best_idx_q  <= new_best_idx;
					best_prio_q <= new_best_prio;
					best_data_q <= new_best_data;
					if (last_scan) begin
						if (need_shift) begin
							done_q  <= 1'b0;
							state_q <= S_SHIFT;
							idx_q   <= new_best_idx;
						end else begin
							state_q         <= S_IDLE;
							done_q          <= 1'b1;
							rsp_q.status    <= ST_OK;
							rsp_q.data_out  <= new_best_data;
							rsp_q.occupancy <= 5'(deq_q ? count_m1 : count_q);
							if (deq_q) begin
								count_q <= count_m1;
							end
						end
					end else begin
						done_q <= 1'b0;
						idx_q  <= idx_q + IDX_W'(1);
					end
				end
				S_SHIFT: begin
					idx_q <= idx_q + IDX_W'(1);
					if (last_shift) begin
						state_q         <= S_IDLE;
						done_q          <= 1'b1;
						rsp_q.status    <= ST_OK;
						rsp_q.data_out  <= best_data_q;
						rsp_q.occupancy <= 5'(count_m1);
						count_q         <= count_m1;
					end else begin
						done_q <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
					done_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	// result strobe only after the sequencer is back in idle
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result strobe while busy");

	// occupancy never exceeds the array depth
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CNT_W'(DEPTH))
		else $error("entry count beyond depth");

	// overflow only reported with a full array and no data
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == ST_OVERFLOW) |-> (rsp.occupancy == 5'(DEPTH) && rsp.data_out == '0))
		else $error("overflow without full array");

	// underflow only reported when empty
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == ST_UNDERFLOW) |-> (rsp.occupancy == '0 && rsp.data_out == '0))
		else $error("underflow with entries held");

	// a shift pass only follows a dequeue scan
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT) |-> deq_q)
		else $error("shift without dequeue");

endmodule
